### rtl/core/lru_key_value_cache_unit_assert.svh
// assertion macros shared by the lru key-value cache checker
`ifndef LRU_KEY_VALUE_CACHE_UNIT_ASSERT_SVH
`define LRU_KEY_VALUE_CACHE_UNIT_ASSERT_SVH

// same-cycle implication, off while reset is high
`define LKVC_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, off while reset is high
`define LKVC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// next-cycle implication that also covers reset itself
`define LKVC_ASSERT_RST(label, ante, cons, msg) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/core/lkvc_pkg.sv
// shared types and constants of the lru key-value cache
`default_nettype none

package lkvc_pkg;

   localparam int KEY_W     = 32;
   localparam int VAL_W     = 32;
   localparam int CAP_W     = 5;
   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

   // request kind carried in req_tuser
   typedef enum logic {
      ACT_GET = 1'b0,
      ACT_PUT = 1'b1
   } lkvc_action_type;

   // decision of the directory for the value store
   typedef struct packed {
      logic found;     // key was present before this transaction
      logic wr;        // write the value at the chosen slot
      logic rd;        // read the value at the chosen slot
   } lkvc_ctl_type;

endpackage

`default_nettype wire

### rtl/core/lkvc_dir.sv
// key directory: parallel key match, recency ranks, valid bits and occupancy
`default_nettype none

module lkvc_dir
   import lkvc_pkg::*;
#(
   parameter int MAX_ENTRIES = 16
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    fire,
   input  wire lkvc_action_type         action,
   input  wire logic [KEY_W-1:0]        key,
   input  wire logic [CAP_W-1:0]        capacity,
   output lkvc_ctl_type                 ctl,
   output logic [((MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1)-1:0] slot
);

   localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int OCC_W = $clog2(MAX_ENTRIES + 1);
   localparam int CMP_W = (OCC_W > CAP_W) ? OCC_W : CAP_W;

   logic [KEY_W-1:0]       keys_ff  [MAX_ENTRIES];
   logic [IDX_W-1:0]       rank_ff  [MAX_ENTRIES];
   logic [MAX_ENTRIES-1:0] valid_ff;
   logic [OCC_W-1:0]       occ_ff;
   logic [OCC_W-1:0]       occ_in;

   logic [MAX_ENTRIES-1:0] hit_vec;
   logic [MAX_ENTRIES-1:0] evict_vec;
   logic [IDX_W-1:0]       hit_idx;
   logic [IDX_W-1:0]       evict_idx;
   logic [IDX_W-1:0]       free_idx;
   logic [IDX_W-1:0]       hit_rank;
   logic [OCC_W-1:0]       occ_m1;
   logic [CMP_W-1:0]       eff_cap;
   logic                   full;
   logic                   is_put;
   logic                   found;
   logic                   touch;

   assign is_put = (action == ACT_PUT);
   assign occ_m1 = occ_ff - 1'b1;

   // capacity clamped to the range one .. MAX_ENTRIES
   always_comb begin
      eff_cap = CMP_W'(capacity);
      if (capacity == '0) begin
         eff_cap = CMP_W'(1);
      end else if (CMP_W'(capacity) > CMP_W'(MAX_ENTRIES)) begin
         eff_cap = CMP_W'(MAX_ENTRIES);
      end
   end

   assign full = (CMP_W'(occ_ff) >= eff_cap) && (occ_ff != '0);

   // parallel key compare and oldest-entry match
   always_comb begin
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         hit_vec[i]   = valid_ff[i] && (keys_ff[i] == key);
         evict_vec[i] = valid_ff[i] && (OCC_W'(rank_ff[i]) == occ_m1);
      end
   end

   // one-hot to index, and the rank of the hit entry
   always_comb begin
      hit_idx   = '0;
      evict_idx = '0;
      hit_rank  = '0;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         if (hit_vec[i]) begin
            hit_idx  = hit_idx | IDX_W'(i);
            hit_rank = hit_rank | rank_ff[i];
         end
         if (evict_vec[i]) begin
            evict_idx = evict_idx | IDX_W'(i);
         end
      end
   end

   // lowest free entry
   always_comb begin
      free_idx = '0;
      for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_idx = IDX_W'(i);
         end
      end
   end

   assign found = |hit_vec;
   assign touch = found || is_put;

   always_comb begin
      if (found) begin
         slot = hit_idx;
      end else if (full) begin
         slot = evict_idx;
      end else begin
         slot = free_idx;
      end
   end

   assign ctl.found = found;
   assign ctl.wr    = is_put;
   assign ctl.rd    = !is_put && found;

   // occupancy grows only on an insert into a free entry
   always_comb begin
      occ_in = occ_ff;
      if (is_put && !found && !full) begin
         occ_in = occ_ff + 1'b1;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         occ_ff   <= '0;
      end else if (fire) begin
         occ_ff <= occ_in;
         if (is_put && !found) begin
            valid_ff[slot] <= 1'b1;
         end
      end
   end

   // keys and recency ranks
   always_ff @(posedge clock) begin
      if (fire && touch) begin
         for (int i = 0; i < MAX_ENTRIES; i++) begin
            if (IDX_W'(i) == slot) begin
               rank_ff[i] <= '0;
            end else if (valid_ff[i] && (!found || (rank_ff[i] < hit_rank))) begin
               rank_ff[i] <= rank_ff[i] + 1'b1;
            end
         end
         if (is_put && !found) begin
            keys_ff[slot] <= key;
         end
      end
   end

endmodule

`default_nettype wire

### rtl/core/lkvc_vals.sv
// value store: one-port memory with registered read data
`default_nettype none

module lkvc_vals
   import lkvc_pkg::*;
#(
   parameter int MAX_ENTRIES = 16
) (
   input  wire logic                    clock,
   input  wire logic                    fire,
   input  wire lkvc_ctl_type            ctl,
   input  wire logic [((MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1)-1:0] slot,
   input  wire logic [VAL_W-1:0]        wr_value,
   output logic [VAL_W-1:0]             rd_value
);

   logic [VAL_W-1:0] mem [MAX_ENTRIES];
   logic [VAL_W-1:0] rdata_ff;

   // a transaction writes, reads or does neither, never both
   always_ff @(posedge clock) begin
      if (fire) begin
         if (ctl.wr) begin
            mem[slot] <= wr_value;
         end else if (ctl.rd) begin
            rdata_ff <= mem[slot];
         end
      end
   end

   assign rd_value = rdata_ff;

endmodule

`default_nettype wire

### rtl/core/lru_key_value_cache_unit.sv
// top level of the fully associative lru key-value cache
//
//   channel | dir | tdata                          | tuser
//   req_    | in  | key [31:0], value [63:32]      | action (0 get, 1 put)
//   rsp_    | out | read_value [31:0]              | found
//   csr_    | in  | capacity, write only           | -
//
// one transaction per cycle while rsp_tready does not stall the result; the
// response passes the input register, then the result register, before
// rsp_tvalid rises. the rate is set by the directory update: parallel key
// compare plus recency rank update.
// reset clears valid bits and occupancy at once, no clearing pass.
// with rsp_tready low the result holds and one more request is taken into
// the input register before req_tready drops.
`default_nettype none

module lru_key_value_cache_unit
   import lkvc_pkg::*;
#(
   parameter int MAX_ENTRIES = 16
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   // request channel
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   input  wire logic [63:0]          req_tdata,   // key [31:0], value [63:32]
   input  wire logic                 req_tuser,   // action [0]
   // response channel
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   output logic [31:0]               rsp_tdata,   // read_value [31:0]
   output logic                      rsp_tuser,   // found [0]
   // configuration
   input  wire logic                 csr_wr_en,
   input  wire logic [CAP_W-1:0]     csr_wr_data
);

   localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

   logic                 in_vld_ff;
   logic                 in_vld_in;
   lkvc_action_type      in_act_ff;
   logic [KEY_W-1:0]     in_key_ff;
   logic [VAL_W-1:0]     in_val_ff;
   logic                 rsp_vld_ff;
   logic                 rsp_vld_in;
   logic                 found_ff;
   logic                 get_hit_ff;
   logic [CAP_W-1:0]     cap_ff;
   logic                 fire;
   logic                 req_acc;
   lkvc_ctl_type         ctl;
   logic [IDX_W-1:0]     slot;
   logic [VAL_W-1:0]     rd_value;

   // stage handshake
   assign fire       = in_vld_ff && (!rsp_vld_ff || rsp_tready);
   assign req_tready = !in_vld_ff || fire;
   assign req_acc    = req_tvalid && req_tready;

   always_comb begin
      in_vld_in = in_vld_ff;
      if (req_acc) begin
         in_vld_in = 1'b1;
      end else if (fire) begin
         in_vld_in = 1'b0;
      end
   end

   always_comb begin
      rsp_vld_in = rsp_vld_ff;
      if (fire) begin
         rsp_vld_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_vld_in = 1'b0;
      end
   end

   // control registers and capacity
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
         cap_ff     <= CAP_RESET;
      end else begin
         in_vld_ff  <= in_vld_in;
         rsp_vld_ff <= rsp_vld_in;
         if (csr_wr_en) begin
            cap_ff <= csr_wr_data;
         end
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (req_acc) begin
         in_act_ff <= lkvc_action_type'(req_tuser);
         in_key_ff <= req_tdata[KEY_W-1:0];
         in_val_ff <= req_tdata[KEY_W+VAL_W-1:KEY_W];
      end
   end

   // result flags
   always_ff @(posedge clock) begin
      if (fire) begin
         found_ff   <= ctl.found;
         get_hit_ff <= ctl.rd;
      end
   end

   lkvc_dir #(
      .MAX_ENTRIES (MAX_ENTRIES)
   ) u_dir (
      .clock    (clock),
      .reset    (reset),
      .fire     (fire),
      .action   (in_act_ff),
      .key      (in_key_ff),
      .capacity (cap_ff),
      .ctl      (ctl),
      .slot     (slot)
   );

   lkvc_vals #(
      .MAX_ENTRIES (MAX_ENTRIES)
   ) u_vals (
      .clock    (clock),
      .fire     (fire),
      .ctl      (ctl),
      .slot     (slot),
      .wr_value (in_val_ff),
      .rd_value (rd_value)
   );

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tuser  = found_ff;
   assign rsp_tdata  = get_hit_ff ? rd_value : '0;

endmodule

`default_nettype wire

### rtl/core/lkvc_checker.sv
// port-level checker for the lru key-value cache, bound to the top level
`default_nettype none

`include "lru_key_value_cache_unit_assert.svh"

module lkvc_checker (
   input wire logic                 clock,
   input wire logic                 reset,
   input wire logic                 req_tready,
   input wire logic                 rsp_tvalid,
   input wire logic                 rsp_tready,
   input wire logic [31:0]          rsp_tdata,
   input wire logic                 rsp_tuser
);

   // reset empties the result register
   `LKVC_ASSERT_RST(a_rst_empty, reset, !rsp_tvalid, "result valid right after reset")

   // a stalled result keeps its payload
   `LKVC_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "stalled result changed")

   // a miss, get or put, never carries a value; a put that hits is not covered
   `LKVC_ASSERT_SAME(a_miss_zero, rsp_tvalid && !rsp_tuser, rsp_tdata == '0, "miss with nonzero value")

   // requests back up only behind a stalled result
   `LKVC_ASSERT_SAME(a_bp_cause, !req_tready, rsp_tvalid && !rsp_tready, "req_tready low without stall")

endmodule

bind lru_key_value_cache_unit lkvc_checker u_lkvc_checker (.*);

`default_nettype wire
